[src/aip_pkg.sv]
package aip_pkg;

    localparam int DATA_WIDTH     = 32;
    localparam int STORE_DEPTH    = 27;
    localparam int ADDR_WIDTH     = $clog2(STORE_DEPTH);
    localparam int ROTOR_WIDTH    = 31;
    localparam int CFG_DATA_WIDTH = 31;
    localparam int DIV_STEPS      = DATA_WIDTH;
    localparam int STEP_WIDTH     = $clog2(DIV_STEPS);

    // Selector code that addresses nothing, and the last valid row, column or matrix.
    localparam logic [1:0] SEL_INVALID = 2'd3;
    localparam logic [1:0] IDX_MAX     = 2'd2;
    localparam logic [1:0] AXIS_Z      = 2'd2;

    // Configuration register indexes.
    localparam logic REG_JOINT_AXIS    = 1'b0;
    localparam logic REG_ROTOR_INERTIA = 1'b1;

    typedef struct packed {
        logic [1:0]                     matrix_sel;
        logic [1:0]                     row_index;
        logic [1:0]                     col_index;
        logic signed [DATA_WIDTH-1:0]   element_value;
        logic                           load_last;
    } in_word_t;

    typedef struct packed {
        logic [1:0]                     out_matrix;
        logic [1:0]                     out_row;
        logic [1:0]                     out_col;
        logic signed [DATA_WIDTH-1:0]   out_value;
        logic                           divisor_zero;
        logic                           out_last;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_D,
        ST_CALC_D,
        ST_RD_A,
        ST_RD_B,
        ST_RD_M,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_OUT
    } ctl_state_t;

    typedef enum logic [1:0] {
        OPND_D,
        OPND_A,
        OPND_B,
        OPND_M
    } opnd_t;

    typedef struct packed {
        logic       load_en;
        opnd_t      rd_opnd;
        logic       cap_a;
        logic       cap_b;
        logic       mul_en;
        logic       calc_d;
        logic       div_init;
        logic       div_step;
        logic       out_load;
        logic       out_last;
        logic [1:0] mat;
        logic [1:0] row;
        logic [1:0] col;
    } dp_cmd_t;

    typedef struct packed {
        logic dzero;
        logic out_free;
    } dp_status_t;

endpackage

[src/aip_datapath.sv]
module aip_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wen,
    input  logic                              cfg_index,
    input  logic [aip_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
    input  aip_pkg::in_word_t                 s_word,
    output aip_pkg::out_word_t                m_word,
    output logic                              m_valid,
    input  logic                              m_ready,
    input  aip_pkg::dp_cmd_t                  cmd,
    output aip_pkg::dp_status_t               status
);
    import aip_pkg::*;

    localparam logic [DATA_WIDTH-1:0] SIGN_BIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic signed [DATA_WIDTH-1:0] store_mem [STORE_DEPTH];

    logic [1:0]                   joint_axis_reg, joint_axis_next;
    logic [ROTOR_WIDTH-1:0]       rotor_inertia_reg, rotor_inertia_next;
    logic signed [DATA_WIDTH-1:0] rdata_reg;
    logic signed [DATA_WIDTH-1:0] a_reg, a_next;
    logic signed [DATA_WIDTH-1:0] b_reg, b_next;
    logic signed [DATA_WIDTH-1:0] m_reg, m_next;
    logic [2*DATA_WIDTH-1:0]      prod_reg, prod_next;
    logic                         qneg_reg, qneg_next;
    logic [DATA_WIDTH-1:0]        dmag_reg, dmag_next;
    logic                         dneg_reg, dneg_next;
    logic [DATA_WIDTH-1:0]        rem_reg, rem_next;
    logic [DATA_WIDTH-1:0]        work_reg, work_next;
    logic                         ovf_reg, ovf_next;
    out_word_t                    out_reg, out_next;
    logic                         m_valid_reg, m_valid_next;

    logic [1:0]            axis;
    logic [ADDR_WIDTH-1:0] k5, i5, j5, mat5;
    logic [ADDR_WIDTH-1:0] raddr, waddr;
    logic                  wen;
    logic [DATA_WIDTH-1:0] mag_a, mag_b;
    logic [DATA_WIDTH-1:0] s_neg;
    logic [DATA_WIDTH:0]   shifted;
    logic                  step_ge;
    logic [DATA_WIDTH-1:0] biased, room, res_u;
    logic signed [DATA_WIDTH-1:0] res_val;

    // An axis code of three acts as the z axis.
    assign axis = (joint_axis_reg == SEL_INVALID) ? AXIS_Z : joint_axis_reg;
    assign k5   = ADDR_WIDTH'(axis);
    assign i5   = ADDR_WIDTH'(cmd.row);
    assign j5   = ADDR_WIDTH'(cmd.col);
    assign mat5 = ADDR_WIDTH'(cmd.mat);

    always_comb begin
        case (cmd.rd_opnd)
            OPND_D: raddr = ADDR_WIDTH'(18) + k5 * ADDR_WIDTH'(4);
            OPND_A: begin
                if (cmd.mat == 2'd0) begin
                    raddr = ADDR_WIDTH'(9) + k5 * ADDR_WIDTH'(3) + i5;
                end else begin
                    raddr = ADDR_WIDTH'(18) + i5 * ADDR_WIDTH'(3) + k5;
                end
            end
            OPND_B: begin
                if (cmd.mat == IDX_MAX) begin
                    raddr = ADDR_WIDTH'(18) + k5 * ADDR_WIDTH'(3) + j5;
                end else begin
                    raddr = ADDR_WIDTH'(9) + k5 * ADDR_WIDTH'(3) + j5;
                end
            end
            default: raddr = mat5 * ADDR_WIDTH'(9) + i5 * ADDR_WIDTH'(3) + j5;
        endcase
    end

    assign wen = cmd.load_en && (s_word.matrix_sel != SEL_INVALID)
                 && (s_word.row_index != SEL_INVALID) && (s_word.col_index != SEL_INVALID);
    assign waddr = ADDR_WIDTH'(s_word.matrix_sel) * ADDR_WIDTH'(9)
                 + ADDR_WIDTH'(s_word.row_index) * ADDR_WIDTH'(3)
                 + ADDR_WIDTH'(s_word.col_index);

    always_ff @(posedge aclk) begin
        if (wen) begin
            store_mem[waddr] <= s_word.element_value;
        end
        rdata_reg <= store_mem[raddr];
    end

    assign mag_a = a_reg[DATA_WIDTH-1] ? (~a_reg + 1'b1) : a_reg;
    assign mag_b = b_reg[DATA_WIDTH-1] ? (~b_reg + 1'b1) : b_reg;
    assign s_neg = ~rdata_reg + 1'b1;

    // One restoring step: the partial remainder stays below the divisor unless the quotient overflows.
    assign shifted = {rem_reg, work_reg[DATA_WIDTH-1]};
    assign step_ge = shifted >= {1'b0, dmag_reg};

    // Saturating subtract worked in offset binary, as the quotient is a magnitude.
    assign biased = m_reg ^ SIGN_BIT;
    assign room   = ~biased;

    always_comb begin
        if (!qneg_reg) begin
            res_u = (ovf_reg || (work_reg > biased)) ? '0 : biased - work_reg;
        end else begin
            res_u = (ovf_reg || (work_reg > room)) ? '1 : biased + work_reg;
        end
        res_val = (dmag_reg == '0) ? m_reg : (res_u ^ SIGN_BIT);
    end

    always_comb begin
        joint_axis_next    = joint_axis_reg;
        rotor_inertia_next = rotor_inertia_reg;
        if (cfg_wen) begin
            case (cfg_index)
                REG_JOINT_AXIS:    joint_axis_next = cfg_wdata[1:0];
                REG_ROTOR_INERTIA: rotor_inertia_next = cfg_wdata[ROTOR_WIDTH-1:0];
                default:           joint_axis_next = joint_axis_reg;
            endcase
        end

        a_next    = cmd.cap_a ? rdata_reg : a_reg;
        b_next    = cmd.cap_b ? rdata_reg : b_reg;
        m_next    = cmd.mul_en ? rdata_reg : m_reg;
        prod_next = cmd.mul_en ? (2*DATA_WIDTH)'(mag_a) * (2*DATA_WIDTH)'(mag_b) : prod_reg;
        qneg_next = cmd.mul_en ? (a_reg[DATA_WIDTH-1] ^ b_reg[DATA_WIDTH-1] ^ dneg_reg)
                               : qneg_reg;

        dmag_next = dmag_reg;
        dneg_next = dneg_reg;
        if (cmd.calc_d) begin
            if (!rdata_reg[DATA_WIDTH-1]) begin
                dneg_next = 1'b0;
                dmag_next = rdata_reg + DATA_WIDTH'(rotor_inertia_reg);
            end else begin
                dneg_next = DATA_WIDTH'(rotor_inertia_reg) < s_neg;
                dmag_next = dneg_next ? s_neg - DATA_WIDTH'(rotor_inertia_reg)
                                      : DATA_WIDTH'(rotor_inertia_reg) - s_neg;
            end
        end

        rem_next  = rem_reg;
        work_next = work_reg;
        ovf_next  = ovf_reg;
        if (cmd.div_init) begin
            rem_next  = prod_reg[2*DATA_WIDTH-1:DATA_WIDTH];
            work_next = prod_reg[DATA_WIDTH-1:0];
            // A quotient that needs more than one word saturates either way.
            ovf_next  = prod_reg[2*DATA_WIDTH-1:DATA_WIDTH] >= dmag_reg;
        end else if (cmd.div_step) begin
            rem_next  = step_ge ? DATA_WIDTH'(shifted - {1'b0, dmag_reg})
                                : shifted[DATA_WIDTH-1:0];
            work_next = {work_reg[DATA_WIDTH-2:0], step_ge};
        end

        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            out_next.out_matrix   = cmd.mat;
            out_next.out_row      = cmd.row;
            out_next.out_col      = cmd.col;
            out_next.out_value    = res_val;
            out_next.divisor_zero = (dmag_reg == '0);
            out_next.out_last     = cmd.out_last;
            m_valid_next          = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            joint_axis_reg    <= AXIS_Z;
            rotor_inertia_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            joint_axis_reg    <= joint_axis_next;
            rotor_inertia_reg <= rotor_inertia_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        m_reg    <= m_next;
        prod_reg <= prod_next;
        qneg_reg <= qneg_next;
        dmag_reg <= dmag_next;
        dneg_reg <= dneg_next;
        rem_reg  <= rem_next;
        work_reg <= work_next;
        ovf_reg  <= ovf_next;
        out_reg  <= out_next;
    end

    assign m_word          = out_reg;
    assign m_valid         = m_valid_reg;
    assign status.dzero    = (dmag_reg == '0);
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

[src/aip_ctrl.sv]
module aip_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                load_last,
    output aip_pkg::dp_cmd_t    cmd,
    input  aip_pkg::dp_status_t status
);
    import aip_pkg::*;

    ctl_state_t            state_reg, state_next;
    logic [1:0]            mat_reg, mat_next;
    logic [1:0]            row_reg, row_next;
    logic [1:0]            col_reg, col_next;
    logic [STEP_WIDTH-1:0] step_reg, step_next;
    logic                  last_elem;

    assign last_elem = (mat_reg == IDX_MAX) && (row_reg == IDX_MAX) && (col_reg == IDX_MAX);

    always_comb begin
        state_next = state_reg;
        mat_next   = mat_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        step_next  = step_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.rd_opnd = OPND_M;
        cmd.mat    = mat_reg;
        cmd.row    = row_reg;
        cmd.col    = col_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_en = 1'b1;
                    if (load_last) begin
                        mat_next   = '0;
                        row_next   = '0;
                        col_next   = '0;
                        state_next = ST_RD_D;
                    end
                end
            end
            ST_RD_D: begin
                cmd.rd_opnd = OPND_D;
                state_next  = ST_CALC_D;
            end
            ST_CALC_D: begin
                cmd.calc_d = 1'b1;
                state_next = ST_RD_A;
            end
            ST_RD_A: begin
                cmd.rd_opnd = OPND_A;
                state_next  = ST_RD_B;
            end
            ST_RD_B: begin
                cmd.rd_opnd = OPND_B;
                cmd.cap_a   = 1'b1;
                state_next  = ST_RD_M;
            end
            ST_RD_M: begin
                cmd.rd_opnd = OPND_M;
                cmd.cap_b   = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = status.dzero ? ST_OUT : ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_WIDTH'(DIV_STEPS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = last_elem;
                    if (col_reg == IDX_MAX) begin
                        col_next = '0;
                        if (row_reg == IDX_MAX) begin
                            row_next = '0;
                            mat_next = (mat_reg == IDX_MAX) ? 2'd0 : mat_reg + 1'b1;
                        end else begin
                            row_next = row_reg + 1'b1;
                        end
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                    state_next = last_elem ? ST_IDLE : ST_RD_A;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mat_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            mat_reg   <= mat_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            step_reg  <= step_next;
        end
    end

endmodule

[src/articulated_inertia_projection.sv]
// Loads are accepted while idle; a load without the last flag produces nothing.
// After the last load the divisor is formed; then each result takes operand reads and a
// multiply, a load of the divider, the divider steps and a step to register the word,
// the divider being skipped with a zero divisor; a word waits while the output is full.
// The next load is taken as soon as the 27th word sits in the output register.
// Reset (synchronous, active low) clears control state and restores axis z, zero rotor.
module articulated_inertia_projection (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wen,
    input  logic                               cfg_index,
    input  logic [aip_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  aip_pkg::in_word_t                  s_word,
    output logic                               m_valid,
    input  logic                               m_ready,
    output aip_pkg::out_word_t                 m_word
);
    import aip_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    aip_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .load_last (s_word.load_last),
        .cmd       (cmd),
        .status    (status)
    );

    aip_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_word    (s_word),
        .m_word    (m_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
